>>> hdl/length_prefixed_frame_ring_buffer_defines.svh
// assertion macros for the length-prefixed frame ring buffer
`ifndef LENGTH_PREFIXED_FRAME_RING_BUFFER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RING_BUFFER_DEFINES_SVH

// property checked on every clock edge outside reset
`define LPFRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define LPFRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lpfrb_pkg.sv
// shared constants and types for the length-prefixed frame ring buffer
`default_nettype none

package lpfrb_pkg;

  localparam int DEPTH     = 4096;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int BYTE_W    = 8;
  localparam int MSG_W     = 16;
  localparam int TOTAL_W   = 16;
  localparam int PLEN_W    = 12;
  localparam int KIND_W    = 3;

  localparam int SIZE_BYTES = 2;
  localparam int HEAD_BYTES = 2;
  localparam int PREFIX_BYTES = SIZE_BYTES + HEAD_BYTES;

  // result tdata layout, lowest bit up
  localparam int DATA_LSB  = 0;
  localparam int MSG_LSB   = DATA_LSB + BYTE_W;
  localparam int PLEN_LSB  = MSG_LSB + MSG_W;
  localparam int FILL_LSB  = PLEN_LSB + PLEN_W;
  localparam int FIELDS_W  = FILL_LSB + CNT_W;
  localparam int TDATA_W   = ((FIELDS_W + 7) / 8) * 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NOTHING = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSHED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BADLEN  = 3'd5;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic              we;
    addr_t             waddr;
    logic [BYTE_W-1:0] wdata;
    addr_t             raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hdl/length_prefixed_frame_ring_buffer.sv
// top level of the length-prefixed frame ring buffer
//
// Received bytes are pushed into a 4096-byte ring and popped back out only
// as whole frames: a 2-byte little-endian total size (counting itself), a
// 2-byte little-endian message id, then total-4 payload bytes. A pop outside
// a frame returns the frame start once the whole frame is held, a pop inside
// a frame returns the next payload byte with tlast on the final one, and a
// size below 4 or above the ring depth is reported as bad length with its
// two size bytes discarded. Every transfer in gives exactly one transfer out.
// One item is processed at a time and the byte store has a single read
// port: a push ends in EXEC, a payload pop in PAY, a pop that finds too
// few bytes in EXEC or SIZE1, a bad length in SIZE1 and a frame start in
// HEAD1, and the result register is loaded only when the output is free.
// The next item is accepted while a result waits.
`default_nettype none

module length_prefixed_frame_ring_buffer import lpfrb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [BYTE_W-1:0]  s_tdata,   // in_byte
  input  wire logic               s_tuser,   // op
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,   // data_byte, message_id, payload_length, fill_level
  output logic [KIND_W-1:0]       m_tuser,   // kind
  output logic                    m_tlast
);

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rdata;

  lpfrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .mem_req  (mem_req),
    .rdata    (rdata)
  );

  lpfrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

>>> hdl/lpfrb_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module lpfrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/lpfrb_ctrl.sv
// pointer, frame state and result sequencer around the byte store
`default_nettype none

module lpfrb_ctrl import lpfrb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [BYTE_W-1:0]  s_tdata,
  input  wire logic               s_tuser,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,
  output logic [KIND_W-1:0]       m_tuser,
  output logic                    m_tlast,
  output mem_req_t                mem_req,
  input  wire logic [BYTE_W-1:0]  rdata
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EXEC  = 7'b0000010,
    ST_PAY   = 7'b0000100,
    ST_SIZE0 = 7'b0001000,
    ST_SIZE1 = 7'b0010000,
    ST_HEAD0 = 7'b0100000,
    ST_HEAD1 = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t        state, state_next;
  logic               op;
  logic [BYTE_W-1:0]  in_byte;
  addr_t              rp, rp_next;
  addr_t              wp, wp_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               in_frame, in_frame_next;
  logic [PLEN_W-1:0]  payload_left, payload_left_next;
  logic [BYTE_W-1:0]  low, low_next;
  logic [PLEN_W-1:0]  plen, plen_next;
  logic [TOTAL_W-1:0] total;
  logic               out_free;
  logic               load;
  logic [KIND_W-1:0]  res_kind;
  logic [BYTE_W-1:0]  res_data;
  logic [MSG_W-1:0]   res_msg;
  logic [PLEN_W-1:0]  res_plen;
  logic               res_last;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign total    = {rdata, low};

  always_comb begin
    state_next        = state;
    rp_next           = rp;
    wp_next           = wp;
    count_next        = count;
    in_frame_next     = in_frame;
    payload_left_next = payload_left;
    low_next          = low;
    plen_next         = plen;
    load              = 1'b0;
    res_kind          = KIND_NOTHING;
    res_data          = '0;
    res_msg           = '0;
    res_plen          = '0;
    res_last          = 1'b0;
    mem_req.we        = 1'b0;
    mem_req.waddr     = wp;
    mem_req.wdata     = in_byte;
    mem_req.raddr     = rp;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op == OP_PUSH) begin
          if (out_free) begin
            load       = 1'b1;
            state_next = ST_IDLE;
            if (32'(count) >= DEPTH) begin
              res_kind = KIND_DROPPED;
            end else begin
              mem_req.we = 1'b1;
              wp_next    = wp + addr_t'(1);
              count_next = count + CNT_W'(1);
              res_kind   = KIND_PUSHED;
            end
          end
        end else if (in_frame) begin
          if (count != '0 && payload_left != '0) begin
            state_next = ST_PAY;
          end else if (out_free) begin
            load              = 1'b1;
            in_frame_next     = 1'b0;
            payload_left_next = '0;
            state_next        = ST_IDLE;
          end
        end else if (32'(count) >= SIZE_BYTES) begin
          state_next = ST_SIZE0;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PAY: begin
        if (out_free) begin
          load              = 1'b1;
          res_kind          = KIND_PAYLOAD;
          res_data          = rdata;
          rp_next           = rp + addr_t'(1);
          count_next        = count - CNT_W'(1);
          payload_left_next = payload_left - PLEN_W'(1);
          if (payload_left == PLEN_W'(1)) begin
            in_frame_next = 1'b0;
            res_last      = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_SIZE0: begin
        mem_req.raddr = rp + addr_t'(1);
        low_next      = rdata;
        state_next    = ST_SIZE1;
      end
      ST_SIZE1: begin
        mem_req.raddr = rp + addr_t'(1);
        if (32'(total) < PREFIX_BYTES || 32'(total) > DEPTH) begin
          if (out_free) begin
            load       = 1'b1;
            res_kind   = KIND_BADLEN;
            rp_next    = rp + addr_t'(SIZE_BYTES);
            count_next = count - CNT_W'(SIZE_BYTES);
            state_next = ST_IDLE;
          end
        end else if (32'(count) >= 32'(total)) begin
          mem_req.raddr = rp + addr_t'(2);
          plen_next     = PLEN_W'(total - TOTAL_W'(PREFIX_BYTES));
          state_next    = ST_HEAD0;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_HEAD0: begin
        mem_req.raddr = rp + addr_t'(3);
        low_next      = rdata;
        state_next    = ST_HEAD1;
      end
      ST_HEAD1: begin
        mem_req.raddr = rp + addr_t'(3);
        if (out_free) begin
          load       = 1'b1;
          res_kind   = KIND_START;
          res_msg    = {rdata, low};
          res_plen   = plen;
          rp_next    = rp + addr_t'(PREFIX_BYTES);
          count_next = count - CNT_W'(PREFIX_BYTES);
          if (plen != '0) begin
            in_frame_next     = 1'b1;
            payload_left_next = plen;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rp           <= '0;
      wp           <= '0;
      count        <= '0;
      in_frame     <= 1'b0;
      payload_left <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      rp           <= rp_next;
      wp           <= wp_next;
      count        <= count_next;
      in_frame     <= in_frame_next;
      payload_left <= payload_left_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    low  <= low_next;
    plen <= plen_next;
    if (s_tvalid && s_tready) begin
      op      <= s_tuser;
      in_byte <= s_tdata;
    end
    if (load) begin
      m_tdata  <= TDATA_W'({count_next, res_plen, res_msg, res_data});
      m_tuser  <= res_kind;
      m_tlast  <= res_last;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lpfrb_checker.sv
// port-level checks for the length-prefixed frame ring buffer
`default_nettype none

`include "length_prefixed_frame_ring_buffer_defines.svh"

module lpfrb_checker import lpfrb_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic [KIND_W-1:0]  m_tuser,
  input wire logic               m_tlast
);

  // a stalled result keeps its contents
  `LPFRB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "result changed while stalled")

  // tlast only marks payload bytes
  `LPFRB_ASSERT(a_last_payload, m_tvalid && m_tlast |-> m_tuser == KIND_PAYLOAD,
    "tlast on non-payload result")

  // frame header fields only on a frame start
  `LPFRB_ASSERT(a_head_zero,
    m_tvalid && m_tuser != KIND_START |-> m_tdata[FILL_LSB-1:MSG_LSB] == '0,
    "header fields set outside frame start")

  // a dropped byte means the ring is full
  `LPFRB_ASSERT(a_drop_full,
    m_tvalid && m_tuser == KIND_DROPPED |-> 32'(m_tdata[FILL_LSB +: CNT_W]) == DEPTH,
    "byte dropped while ring not full")

endmodule

bind length_prefixed_frame_ring_buffer lpfrb_checker u_checker (.*);

`default_nettype wire
